>>> rtl/core/pslct_pkg.sv
// shared types, codes and the load cost table of the per-source credit tracker
package pslct_pkg;

   // request action codes
   localparam logic [2:0] ACT_DEBIT  = 3'd0;
   localparam logic [2:0] ACT_CREDIT = 3'd1;
   localparam logic [2:0] ACT_WARN   = 3'd2;
   localparam logic [2:0] ACT_CUTOFF = 3'd3;
   localparam logic [2:0] ACT_TICK   = 3'd4;

   // register indexes on the csr port
   localparam logic [1:0] REG_RATE       = 2'd0;
   localparam logic [1:0] REG_LIMIT      = 2'd1;
   localparam logic [1:0] REG_WARN       = 2'd2;
   localparam logic [1:0] REG_DEBIT_LIM  = 2'd3;

   localparam int NUM_LOAD_TYPES = 10;
   localparam int COST_COUNT     = 10;
   localparam int COST_W         = 7;

   typedef struct packed {
      logic [15:0]        credit_rate;
      logic signed [31:0] credit_limit;
      logic signed [31:0] debit_warn;
      logic signed [31:0] debit_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] balance;
      logic [31:0]        last_update;
      logic [31:0]        last_warning;
   } entry_type;

   // fixed debit per load type, zero for types without a cost
   function automatic logic [COST_W-1:0] load_cost(input logic [3:0] lt);
      logic [COST_W-1:0] c;
      case (lt)
         4'd0: c = 7'd10;
         4'd1: c = 7'd1;
         4'd2: c = 7'd100;
         4'd3: c = 7'd5;
         4'd4: c = 7'd20;
         4'd5: c = 7'd10;
         4'd6: c = 7'd2;
         4'd7: c = 7'd10;
         4'd8: c = 7'd5;
         4'd9: c = 7'd1;
         default: c = '0;
      endcase
      if (!(int'(lt) < NUM_LOAD_TYPES && int'(lt) < COST_COUNT)) c = '0;
      return c;
   endfunction

endpackage

>>> rtl/core/per_source_load_credit_tracker.sv
// Per-source load credit tracker. A request is taken when start is high and busy is low and
// its result is on rsp_valid for one cycle; busy is low in that result cycle, so a new
// request can be taken while the result is shown, but not before. The steps follow the entry
// memory's read-modify-write sequence: the registered read is launched at the accepting edge,
// then ST_READ registers the entry and the accrual multiply, ST_ACCRUE the capped accrual add,
// and ST_UPDATE the adjustment and write-back together with the registered result. After
// reset the entry memory is swept to zero, one entry per cycle, which keeps busy high until
// the sweep is done; csr writes are taken during that time. The receiver cannot stall
// results.
module per_source_load_credit_tracker import pslct_pkg::*; #(
   parameter int NUM_SOURCES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [7:0]         req_source_id,
   input  logic               req_privileged,
   input  logic [3:0]         req_load_type,
   input  logic signed [16:0] req_credits,
   output logic               rsp_valid,
   output logic               rsp_verdict,
   output logic signed [31:0] rsp_balance,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam logic signed [33:0] SAT_MAX = 34'sh07FFFFFFF;
   localparam logic signed [33:0] SAT_MIN = 34'sh380000000;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_ACCRUE = 5'b01000,
      ST_UPDATE = 5'b10000
   } state_type;

   // source index modulo the table depth, by restoring subtraction
   function automatic logic [7:0] src_index(input logic [7:0] src);
      logic [7:0] rem;
      rem = src;
      for (int k = 7; k >= 0; k--) begin
         if (int'(rem) >= (NUM_SOURCES << k)) rem = rem - 8'(NUM_SOURCES << k);
      end
      return rem;
   endfunction

   state_type state_ff, state_in;
   cfg_type   cfg;
   entry_type rd_data, wr_data, ent_ff;
   logic      clear_done, accept, wr_en, access;

   logic [2:0]         act_ff;
   logic               priv_ff;
   logic [3:0]         lt_ff;
   logic signed [16:0] credits_ff;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [31:0]        uptime_ff, uptime_in;

   logic [31:0]        elapsed;
   logic               gain, gain_ff;
   logic [47:0]        prod_in, prod_ff;
   logic signed [49:0] acc_sum, limit_ext;
   logic signed [31:0] bal_acc_in, bal_acc_ff;

   logic signed [33:0] change, adj_sum;
   logic signed [31:0] clamped, adjusted, new_bal;
   logic               warn_hit, cut_hit, verdict;

   logic               rsp_valid_ff, rsp_verdict_ff;
   logic signed [31:0] rsp_balance_ff;

   pslct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pslct_table #(.NUM_SOURCES(NUM_SOURCES), .AW(AW)) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (idx_in),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (idx_ff),
      .wr_data    (wr_data),
      .clear_done (clear_done)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign idx_in = AW'(src_index(req_source_id));

   always_comb begin
      case (state_ff)
         ST_CLEAR:  state_in = clear_done ? ST_IDLE : ST_CLEAR;
         ST_IDLE:   state_in = start ? ST_READ : ST_IDLE;
         ST_READ:   state_in = ST_ACCRUE;
         ST_ACCRUE: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // accrual: elapsed ticks times rate, only for access actions and when last update is behind now
   assign access  = (act_ff <= ACT_CUTOFF);
   assign elapsed = uptime_ff - rd_data.last_update;
   assign gain    = access && (rd_data.last_update != uptime_ff)
                    && ($signed(rd_data.last_update) < $signed(uptime_ff));
   assign prod_in = cfg.credit_rate * elapsed;

   assign acc_sum   = $signed({{18{ent_ff.balance[31]}}, ent_ff.balance})
                      + $signed({2'b00, prod_ff});
   assign limit_ext = $signed({{18{cfg.credit_limit[31]}}, cfg.credit_limit});
   assign bal_acc_in = !gain_ff ? ent_ff.balance :
                       (acc_sum > limit_ext) ? cfg.credit_limit : acc_sum[31:0];

   // adjustment with saturation, then the credit ceiling, and the warning and cutoff verdict
   always_comb begin
      if (act_ff == ACT_DEBIT) begin
         change = 34'sd0 - $signed({27'd0, load_cost(lt_ff)});
      end else begin
         change = $signed({{17{credits_ff[16]}}, credits_ff});
      end
      adj_sum = $signed({{2{bal_acc_ff[31]}}, bal_acc_ff}) + change;
      if (adj_sum > SAT_MAX) begin
         clamped = 32'sh7FFFFFFF;
      end else if (adj_sum < SAT_MIN) begin
         clamped = 32'sh80000000;
      end else begin
         clamped = adj_sum[31:0];
      end
      adjusted = (clamped > cfg.credit_limit) ? cfg.credit_limit : clamped;
      new_bal  = (act_ff == ACT_DEBIT || act_ff == ACT_CREDIT) ? adjusted : bal_acc_ff;
      warn_hit = (new_bal < cfg.debit_warn) && (ent_ff.last_warning != uptime_ff);
      cut_hit  = (new_bal < cfg.debit_limit);
      case (act_ff)
         ACT_DEBIT, ACT_CREDIT: verdict = !priv_ff && (cut_hit || warn_hit);
         ACT_WARN:              verdict = !priv_ff && warn_hit;
         ACT_CUTOFF:            verdict = !priv_ff && cut_hit;
         default:               verdict = 1'b0;
      endcase
   end

   assign wr_en                = (state_ff == ST_UPDATE) && access;
   assign wr_data.balance      = new_bal;
   assign wr_data.last_update  = uptime_ff;
   assign wr_data.last_warning = (act_ff == ACT_WARN && verdict) ? uptime_ff
                                                                 : ent_ff.last_warning;

   assign uptime_in = ((state_ff == ST_UPDATE) && (act_ff == ACT_TICK))
                      ? uptime_ff + 32'd1 : uptime_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         uptime_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         uptime_ff    <= uptime_in;
         rsp_valid_ff <= (state_ff == ST_UPDATE);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff     <= req_action;
         priv_ff    <= req_privileged;
         lt_ff      <= req_load_type;
         credits_ff <= req_credits;
         idx_ff     <= idx_in;
      end
      if (state_ff == ST_READ) begin
         ent_ff  <= rd_data;
         gain_ff <= gain;
         prod_ff <= prod_in;
      end
      if (state_ff == ST_ACCRUE) begin
         bal_acc_ff <= bal_acc_in;
      end
      if (state_ff == ST_UPDATE) begin
         rsp_verdict_ff <= verdict;
         rsp_balance_ff <= new_bal;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;
   assign rsp_balance = rsp_balance_ff;

   a_one_cycle_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      !clear_done |-> busy)
      else $error("not busy while table clear is running");

   a_tick_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && act_ff == ACT_TICK) |-> !rsp_verdict)
      else $error("tick request reported a verdict");

   a_priv_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && priv_ff) |-> !rsp_verdict)
      else $error("privileged source got a verdict");

endmodule

>>> rtl/core/pslct_csr.sv
// apb configuration registers of the credit tracker
module pslct_csr import pslct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_hit;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_hit  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         case (reg_idx)
            REG_RATE:      cfg_in.credit_rate  = pwdata[15:0];
            REG_LIMIT:     cfg_in.credit_limit = pwdata;
            REG_WARN:      cfg_in.debit_warn   = pwdata;
            REG_DEBIT_LIM: cfg_in.debit_limit  = pwdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.credit_rate  <= 16'd10;
         cfg_ff.credit_limit <= 32'sd50;
         cfg_ff.debit_warn   <= -32'sd50;
         cfg_ff.debit_limit  <= -32'sd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_RATE:      prdata = {16'd0, cfg_ff.credit_rate};
         REG_LIMIT:     prdata = cfg_ff.credit_limit;
         REG_WARN:      prdata = cfg_ff.debit_warn;
         REG_DEBIT_LIM: prdata = cfg_ff.debit_limit;
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/pslct_table.sv
// per-source entry memory with registered read and a clearing pass after reset
module pslct_table import pslct_pkg::*; #(
   parameter int NUM_SOURCES = 256,
   parameter int AW          = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   output logic          clear_done
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SOURCES - 1);

   entry_type     mem [NUM_SOURCES];
   entry_type     rd_data_ff;
   logic          clr_active_ff, clr_active_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   assign clr_addr_in   = clr_addr_ff + AW'(1);
   assign clr_active_in = clr_active_ff && (clr_addr_ff != LAST_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_done = !clr_active_ff;

endmodule
